/* hdl/dqa_pkg.sv */
// ----------------------------------------------------------------------------
// dqa_pkg
// Shared constants and types for the dotted-quad address checker.
// ----------------------------------------------------------------------------
package dqa_pkg;

    localparam int MAX_FIELD_CHARS = 63;
    localparam int CNT_W           = $clog2(MAX_FIELD_CHARS + 1);

    localparam logic [8:0] SEG_LIMIT     = 9'd255;
    localparam logic [8:0] SEG_SATURATED = 9'd256;
    localparam logic [2:0] DOTS_NEEDED   = 3'd3;
    localparam logic [2:0] DOT_CAP       = 3'd4;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // register word index
    localparam logic REG_ALLOW_BLANK = 1'b0;

    // one character request handed to the field tracker
    typedef struct packed {
        logic       fire;
        logic [7:0] ch;
        logic       present;
        logic       last;
    } step_t;

    // per-field parse state
    typedef struct packed {
        logic [8:0]       seg;
        logic             has_digit;
        logic [2:0]       dots;
        logic             fmt_err;
        logic             trailing;
        logic             terminated;
        logic             only_spaces;
        logic [CNT_W-1:0] count;
    } field_t;

    localparam field_t FIELD_RESET = '{
        seg:         9'd0,
        has_digit:   1'b0,
        dots:        3'd0,
        fmt_err:     1'b0,
        trailing:    1'b0,
        terminated:  1'b0,
        only_spaces: 1'b1,
        count:       '0
    };

endpackage

/* hdl/dotted_quad_address_checker.sv */
// ----------------------------------------------------------------------------
// dotted_quad_address_checker
// Byte-serial check of an ASCII dotted-quad address field.
// ----------------------------------------------------------------------------
// Path: an accepted last request passes the input register, then the verdict
// register, to address_ok. Throughput: one request per cycle, bounded by the
// dqa_field accumulator; a last request waits on a full, stalled verdict.
// Reset: rst_n clears the field state, allow_blank and both valid flags at
// once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dotted_quad_address_checker
    import dqa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // APB-style register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // character requests
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_byte,
    input  logic        char_present,
    input  logic        last_char,

    // verdicts
    output logic        out_valid,
    input  logic        out_stall,
    output logic        address_ok
);

    // ------------------------------------------------------------------
    // Register port: one word, allow_blank at byte offset 0.
    // ------------------------------------------------------------------
    logic allow_blank_reg;
    logic allow_blank_next;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        allow_blank_next = allow_blank_reg;
        if (cfg_write && (paddr[2] == REG_ALLOW_BLANK))
        begin
            allow_blank_next = pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_ALLOW_BLANK) ? {31'd0, allow_blank_reg} : 32'd0;

    // ------------------------------------------------------------------
    // Input register. The held request moves on unless it is a last
    // request and the verdict register is still full and stalled; a
    // non-last request produces nothing and always moves on.
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] char_byte_reg;
    logic       char_present_reg;
    logic       last_char_reg;
    logic       in_accept;
    logic       advance;

    assign advance   = in_valid_reg && (!last_char_reg || !out_valid || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Field parse state and verdict.
    // ------------------------------------------------------------------
    step_t step;
    logic  verdict;

    assign step.fire    = advance;
    assign step.ch      = char_byte_reg;
    assign step.present = char_present_reg;
    assign step.last    = last_char_reg;

    dqa_field u_field
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .allow_blank (allow_blank_reg),
        .verdict     (verdict)
    );

    // ------------------------------------------------------------------
    // Verdict register.
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic out_valid_next;
    logic address_ok_reg;
    logic address_ok_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        address_ok_next = address_ok_reg;
        if (advance && last_char_reg)
        begin
            out_valid_next  = 1'b1;
            address_ok_next = verdict;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign address_ok = address_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_blank_reg <= 1'b0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            allow_blank_reg <= allow_blank_next;
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            char_byte_reg    <= char_byte;
            char_present_reg <= char_present;
            last_char_reg    <= last_char;
        end
        address_ok_reg <= address_ok_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // stall only ever holds back a request already in the input register
    a_stall_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
        else $error("in_stall raised with empty input register");

    // an accepted request is held on the next cycle
    a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_valid_reg)
        else $error("accepted request lost");

    // a verdict appears only after a last request moved on
    a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(advance && last_char_reg))
        else $error("verdict without a last request");

endmodule

/* hdl/dqa_field.sv */
// ----------------------------------------------------------------------------
// dqa_field
// Per-character parse state and the verdict for a field's last request.
// ----------------------------------------------------------------------------
module dqa_field
    import dqa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  step_t step,
    input  logic  allow_blank,
    output logic  verdict
);

    field_t      state_reg;
    field_t      state_upd;
    field_t      state_next;
    logic        taken;
    logic [11:0] digit_sum;

    assign taken = step.fire && step.present && !state_reg.terminated
                   && (state_reg.count < CNT_W'(MAX_FIELD_CHARS));

    assign digit_sum = (12'(state_reg.seg) * 12'd10) + {8'd0, step.ch[3:0]};

    always_comb
    begin
        state_upd = state_reg;
        if (taken)
        begin
            state_upd.count = state_reg.count + CNT_W'(1);
            if (step.ch != CHAR_SPACE)
            begin
                state_upd.only_spaces = 1'b0;
            end
            priority if (step.ch == CHAR_NUL)
            begin
                state_upd.terminated = 1'b1;
            end
            else if (step.ch == CHAR_SPACE)
            begin
                state_upd.trailing = 1'b1;
            end
            else if (state_reg.trailing)
            begin
                state_upd.fmt_err = 1'b1;
            end
            else if (step.ch == CHAR_DOT)
            begin
                if (!state_reg.has_digit || (state_reg.seg > SEG_LIMIT)
                    || (state_reg.dots >= DOTS_NEEDED))
                begin
                    state_upd.fmt_err = 1'b1;
                end
                if (state_reg.dots < DOT_CAP)
                begin
                    state_upd.dots = state_reg.dots + 3'd1;
                end
                state_upd.seg       = 9'd0;
                state_upd.has_digit = 1'b0;
            end
            else if ((step.ch >= CHAR_ZERO) && (step.ch <= CHAR_NINE))
            begin
                // saturate so an oversized segment stays flagged
                state_upd.seg = (digit_sum > 12'(SEG_LIMIT)) ? SEG_SATURATED
                                                              : digit_sum[8:0];
                state_upd.has_digit = 1'b1;
            end
            else
            begin
                state_upd.fmt_err = 1'b1;
            end
        end
    end

    always_comb
    begin
        verdict = !state_upd.fmt_err && (state_upd.dots == DOTS_NEEDED)
                  && state_upd.has_digit && (state_upd.seg <= SEG_LIMIT);
        if (allow_blank && state_upd.only_spaces)
        begin
            verdict = 1'b1;
        end
    end

    // a verdict clears the field
    assign state_next = (step.fire && step.last) ? FIELD_RESET : state_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FIELD_RESET;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
